// ===== hdl/ebd_pkg.sv =====
// Package for the exponential backoff delay block.
// Holds field widths, register indexes, reset values and the jitter constants.
// No dependencies.
package ebd_pkg;

    // Default values of the top level parameters.
    localparam int DELAY_BITS_DEF       = 32;
    localparam int GROWTH_FRAC_BITS_DEF = 12;

    // Port field widths.
    localparam int ATTEMPT_W   = 10;
    localparam int DELAY_OUT_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int GROWTH_W    = 16;
    localparam int JITTER_W    = 17;

    // The working value carries this many fraction bits.
    localparam int VAL_FRAC = 16;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROWTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER  = 2'd3;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] INITIAL_RST = 32'd100;
    localparam logic [CFG_DATA_W-1:0] MAX_RST     = 32'd30000;
    localparam logic [GROWTH_W-1:0]   GROWTH_RST  = 16'd8192;
    localparam logic [JITTER_W-1:0]   JITTER_RST  = 17'd0;

    // Jitter: a fraction of one in UQ1.16, and the Weyl sequence step.
    localparam logic [JITTER_W-1:0] JIT_ONE   = 17'h10000;
    localparam logic [63:0]         WEYL_STEP = 64'h9E3779B97F4A7C15;

    // Product of the shared multiplier.
    typedef logic [MUL_P_W-1:0] mul_prod_t;

endpackage

// ===== hdl/ebd_mul.sv =====
// Registered 32 x 33 unsigned multiplier shared by every product in the block.
// Depends on ebd_pkg for operand and product widths.
module ebd_mul
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [ebd_pkg::MUL_A_W-1:0] a,
    input  logic [ebd_pkg::MUL_B_W-1:0] b,
    output ebd_pkg::mul_prod_t          p
);
    import ebd_pkg::*;

    mul_prod_t p_reg;
    mul_prod_t p_next;

    // One product per enabled cycle, held until the next one.
    assign p_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== hdl/exponential_backoff_delay_top.sv =====
// Top level of the exponential backoff delay block.
// Depends on ebd_pkg and instantiates the shared multiplier ebd_mul.
//
// Usage: an attempt count is taken at a rising edge where start is high and busy
// is low. The block then stays busy while a small sequencer drives one shared
// registered 32 x 33 multiplier. Each growth step runs two partial products of
// the working value by the growth factor, a sum with shift and cap compare, and
// a check; steps stop early once the value reaches the cap or the growth factor
// is one, and at most attempt_count - 1 steps run. Jitter, when enabled and the
// value is not zero, adds the draw, the magnitude product, two partial products
// of the value, a sum and the apply step. The delay leaves on delay_ms with a
// one cycle done beat; a zero attempt count answers with a zero delay. busy
// falls in the cycle that done is shown, so a new start can be taken in that
// same cycle. The receiver cannot stall: done is shown for one cycle only.
// Configuration writes are taken at any edge with cfg_we high and are meant for
// idle periods. Reset loads the register defaults and the Weyl counter seed and
// leaves the block idle.
module exponential_backoff_delay_top
#(
    parameter int DELAY_BITS       = ebd_pkg::DELAY_BITS_DEF,
    parameter int GROWTH_FRAC_BITS = ebd_pkg::GROWTH_FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ebd_pkg::ATTEMPT_W-1:0]   attempt_count,
    output logic                            done,
    output logic [ebd_pkg::DELAY_OUT_W-1:0] delay_ms,
    input  logic                            cfg_we,
    input  logic [ebd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ebd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ebd_pkg::*;

    // Working value width, stored delay register width, growth width.
    localparam int VW   = DELAY_BITS + VAL_FRAC;
    localparam int IW   = (DELAY_BITS < CFG_DATA_W) ? DELAY_BITS : CFG_DATA_W;
    localparam int GW   = GROWTH_W + 1;
    localparam int GPW  = VW + GW;
    localparam int PADW = 2 * MUL_A_W;

    localparam logic [GW-1:0] G_ONE = GW'(1) << GROWTH_FRAC_BITS;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_GLO    = 4'd2;
    localparam logic [3:0] S_GHI    = 4'd3;
    localparam logic [3:0] S_GSUM   = 4'd4;
    localparam logic [3:0] S_JM     = 4'd5;
    localparam logic [3:0] S_JLO    = 4'd6;
    localparam logic [3:0] S_JHI    = 4'd7;
    localparam logic [3:0] S_JSUM   = 4'd8;
    localparam logic [3:0] S_JAPPLY = 4'd9;

    // Control and configuration state.
    logic [3:0]           state_reg, state_next;
    logic [ATTEMPT_W-1:0] rem_reg, rem_next;
    logic                 done_reg, done_next;
    logic [63:0]          weyl_reg, weyl_next;
    logic [IW-1:0]        initial_reg;
    logic [IW-1:0]        max_reg;
    logic [GROWTH_W-1:0]  growth_reg;
    logic [JITTER_W-1:0]  jitter_reg;

    // Datapath registers.
    logic [VW-1:0]          v_reg, v_next;
    logic [VW-1:0]          cap_reg, cap_next;
    logic [GW-1:0]          g_reg, g_next;
    logic [JITTER_W-1:0]    jit_reg, jit_next;
    logic [JITTER_W-1:0]    mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [MUL_B_W-1:0]     m_reg, m_next;
    mul_prod_t              lo_reg, lo_next;
    logic [VW-1:0]          delta_reg, delta_next;
    logic [DELAY_OUT_W-1:0] delay_reg, delay_next;

    // Shared multiplier port.
    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    mul_prod_t          mul_p;

    // Helper values.
    logic [PADW-1:0]      v_pad;
    logic [MUL_A_W-1:0]   v_lo;
    logic [MUL_A_W-1:0]   v_hi;
    logic [IW-1:0]        cap_ms;
    logic [GPW-1:0]       grow_sum;
    logic [GPW-1:0]       grown;
    logic [VW-1:0]        grow_val;
    logic [63:0]          r1, r2, r3;
    logic [JITTER_W-1:0]  draw;
    logic [VW-1:0]        jit_val;
    logic                 take;

    ebd_mul u_mul
    (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign take  = start && (state_reg == S_IDLE);
    assign v_pad = PADW'(v_reg);
    assign v_lo  = v_pad[MUL_A_W-1:0];
    assign v_hi  = v_pad[PADW-1:MUL_A_W];

    // Cap is the greater of the maximum and the initial delay.
    assign cap_ms = (max_reg < initial_reg) ? initial_reg : max_reg;

    // Growth step: floor(v * g / 2^frac) from two partial products, saturated at the cap.
    assign grow_sum = (GPW'(mul_p) << MUL_A_W) + GPW'(lo_reg);
    assign grown    = grow_sum >> GROWTH_FRAC_BITS;
    assign grow_val = (grown > GPW'(cap_reg)) ? cap_reg : VW'(grown);

    // Xorshift of the Weyl counter; the top 17 bits form the jitter draw.
    assign r1   = weyl_reg ^ (weyl_reg >> 12);
    assign r2   = r1 ^ (r1 << 25);
    assign r3   = r2 ^ (r2 >> 27);
    assign draw = r3[63:47];

    // Apply the jitter offset, clamped to zero below and to the cap above.
    always_comb
    begin
        if (neg_reg)
        begin
            jit_val = (delta_reg >= v_reg) ? '0 : (v_reg - delta_reg);
        end
        else
        begin
            jit_val = (delta_reg > (cap_reg - v_reg)) ? cap_reg : (v_reg + delta_reg);
        end
    end

    // Sequencer and operand selection.
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        weyl_next  = weyl_reg;
        v_next     = v_reg;
        cap_next   = cap_reg;
        g_next     = g_reg;
        jit_next   = jit_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        m_next     = m_reg;
        lo_next    = lo_reg;
        delta_next = delta_reg;
        delay_next = delay_reg;
        mul_en     = 1'b0;
        mul_a      = v_lo;
        mul_b      = MUL_B_W'(g_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cap_next = VW'(cap_ms) << VAL_FRAC;
                    g_next   = (GW'(growth_reg) < G_ONE) ? G_ONE : GW'(growth_reg);
                    jit_next = (jitter_reg > JIT_ONE) ? '0 : jitter_reg;
                    if (attempt_count == '0)
                    begin
                        v_next   = '0;
                        rem_next = '0;
                    end
                    else
                    begin
                        v_next   = VW'(initial_reg) << VAL_FRAC;
                        rem_next = attempt_count - ATTEMPT_W'(1);
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((rem_reg != '0) && (g_reg != G_ONE) && (v_reg < cap_reg))
                begin
                    state_next = S_GLO;
                end
                else if ((jit_reg != '0) && (v_reg != '0))
                begin
                    // Draw once and advance the Weyl counter.
                    weyl_next  = weyl_reg + WEYL_STEP;
                    neg_next   = !draw[JITTER_W-1];
                    mag_next   = draw[JITTER_W-1] ? {1'b0, draw[JITTER_W-2:0]}
                                                  : (JIT_ONE - draw);
                    state_next = S_JM;
                end
                else
                begin
                    done_next  = 1'b1;
                    delay_next = DELAY_OUT_W'(v_reg >> VAL_FRAC);
                    state_next = S_IDLE;
                end
            end
            S_GLO:
            begin
                mul_en     = 1'b1;
                mul_a      = v_lo;
                mul_b      = MUL_B_W'(g_reg);
                state_next = S_GHI;
            end
            S_GHI:
            begin
                mul_en     = 1'b1;
                mul_a      = v_hi;
                mul_b      = MUL_B_W'(g_reg);
                lo_next    = mul_p;
                state_next = S_GSUM;
            end
            S_GSUM:
            begin
                v_next     = grow_val;
                rem_next   = rem_reg - ATTEMPT_W'(1);
                state_next = S_CHECK;
            end
            S_JM:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(mag_reg);
                mul_b      = MUL_B_W'(jit_reg);
                state_next = S_JLO;
            end
            S_JLO:
            begin
                mul_en     = 1'b1;
                mul_a      = v_lo;
                mul_b      = mul_p[MUL_B_W-1:0];
                m_next     = mul_p[MUL_B_W-1:0];
                state_next = S_JHI;
            end
            S_JHI:
            begin
                mul_en     = 1'b1;
                mul_a      = v_hi;
                mul_b      = m_reg;
                lo_next    = mul_p;
                state_next = S_JSUM;
            end
            S_JSUM:
            begin
                // delta = floor(v * m / 2^32); it never exceeds v.
                delta_next = VW'(mul_p + (lo_reg >> MUL_A_W));
                state_next = S_JAPPLY;
            end
            S_JAPPLY:
            begin
                v_next     = jit_val;
                done_next  = 1'b1;
                delay_next = DELAY_OUT_W'(jit_val >> VAL_FRAC);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, Weyl counter and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rem_reg     <= '0;
            done_reg    <= 1'b0;
            weyl_reg    <= WEYL_STEP;
            initial_reg <= IW'(INITIAL_RST);
            max_reg     <= IW'(MAX_RST);
            growth_reg  <= GROWTH_RST;
            jitter_reg  <= JITTER_RST;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            done_reg  <= done_next;
            weyl_reg  <= weyl_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INITIAL: initial_reg <= cfg_data[IW-1:0];
                    REG_MAX:     max_reg     <= cfg_data[IW-1:0];
                    REG_GROWTH:  growth_reg  <= cfg_data[GROWTH_W-1:0];
                    REG_JITTER:  jitter_reg  <= cfg_data[JITTER_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        cap_reg   <= cap_next;
        g_reg     <= g_next;
        jit_reg   <= jit_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        m_reg     <= m_next;
        lo_reg    <= lo_next;
        delta_reg <= delta_next;
        delay_reg <= delay_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign delay_ms = delay_reg;

endmodule

// ===== hdl/ebd_chk.sv =====
// Port level checker for the exponential backoff delay block, bound to the top level.
// Depends on ebd_pkg for port widths.
module ebd_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [ebd_pkg::ATTEMPT_W-1:0]   attempt_count,
    input logic                            done,
    input logic [ebd_pkg::DELAY_OUT_W-1:0] delay_ms
);
    import ebd_pkg::*;

    // A result beat is only shown once the block is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done shown while busy");

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // Each result beat lasts exactly one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Zero attempts answer with a zero delay.
    a_zero_attempts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (attempt_count == '0)) |-> ##2 (done && (delay_ms == '0)))
        else $error("zero attempts did not give a zero delay");

endmodule

bind exponential_backoff_delay_top ebd_chk u_ebd_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .attempt_count (attempt_count),
    .done          (done),
    .delay_ms      (delay_ms)
);
